/* rtl/core/cdk_pkg.sv */
// Shared types, constants, tables and microprogram of the calendar date keeper.
package cdk_pkg;

	localparam int CDK_MAX_YEAR = 9999;
	localparam int CDK_MAX_ADD  = 65535;

	localparam int OPW = 2;
	localparam int YW  = 14;
	localparam int MW  = 4;
	localparam int DW  = 5;
	localparam int NW  = 16;
	localparam int DNW = 22;
	localparam int WKW = 3;
	localparam int TDW = NW + 1;

	localparam int DAYS_YEAR     = 365;
	localparam int RECIP100      = 5243;
	localparam int DIV100_SHIFT  = 19;
	localparam int P100W         = YW + 13;
	localparam int Q100W         = 8;
	localparam int R100W         = 7;
	localparam int R400W         = 9;
	localparam int BASEW         = YW + 9;

	typedef enum logic [OPW-1:0] {
		OP_LOAD = 2'd0,
		OP_SET  = 2'd1,
		OP_ADD  = 2'd2,
		OP_NONE = 2'd3
	} opcode_t;

	typedef enum logic [3:0] {
		DP_NOP,
		DP_LATCH,
		DP_DIV100,
		DP_MOD,
		DP_BASE,
		DP_SUM,
		DP_COMMIT_DATE,
		DP_ADD_INIT,
		DP_ADD_WALK,
		DP_COMMIT_ADD,
		DP_WD_Q,
		DP_WD_R,
		DP_EMIT
	} dp_op_t;

	typedef enum logic [3:0] {
		C_NEVER,
		C_ALWAYS,
		C_NO_WORD,
		C_IS_ADD,
		C_BAD_OP,
		C_DATE_REFUSED,
		C_ADD_REFUSED,
		C_WALKING,
		C_OVER,
		C_OUT_BUSY
	} cond_t;

	localparam int UAW = 4;
	typedef logic [UAW-1:0] uaddr_t;

	localparam uaddr_t UA_IDLE        = 4'd0;
	localparam uaddr_t UA_DISPATCH    = 4'd1;
	localparam uaddr_t UA_DIV100      = 4'd2;
	localparam uaddr_t UA_MOD         = 4'd3;
	localparam uaddr_t UA_BASE        = 4'd4;
	localparam uaddr_t UA_SUM         = 4'd5;
	localparam uaddr_t UA_DATE_CHECK  = 4'd6;
	localparam uaddr_t UA_COMMIT_DATE = 4'd7;
	localparam uaddr_t UA_ADD_INIT    = 4'd9;
	localparam uaddr_t UA_WALK        = 4'd10;
	localparam uaddr_t UA_ADD_CHECK   = 4'd11;
	localparam uaddr_t UA_COMMIT_ADD  = 4'd12;
	localparam uaddr_t UA_WD_Q        = 4'd13;
	localparam uaddr_t UA_WD_R        = 4'd14;
	localparam uaddr_t UA_EMIT        = 4'd15;

	typedef struct packed {
		dp_op_t op;
		cond_t  cond;
		uaddr_t target;
	} uword_t;

	typedef struct packed {
		logic no_word;
		logic is_add;
		logic bad_op;
		logic date_refused;
		logic add_refused;
		logic walking;
		logic over;
		logic out_busy;
	} seq_status_t;

	typedef struct packed {
		dp_op_t op;
		logic   idle;
	} seq_ctrl_t;

	// Branch taken goes to target, otherwise to the next address.
	// EMIT falls through by wrapping to IDLE.
	function automatic uword_t ucode(input uaddr_t a);
		uword_t w;
		begin
			unique case (a)
				UA_IDLE:        w = '{DP_LATCH,       C_NO_WORD,      UA_IDLE};
				UA_DISPATCH:    w = '{DP_NOP,         C_IS_ADD,       UA_ADD_INIT};
				UA_DIV100:      w = '{DP_DIV100,      C_BAD_OP,       UA_EMIT};
				UA_MOD:         w = '{DP_MOD,         C_NEVER,        UA_IDLE};
				UA_BASE:        w = '{DP_BASE,        C_NEVER,        UA_IDLE};
				UA_SUM:         w = '{DP_SUM,         C_NEVER,        UA_IDLE};
				UA_DATE_CHECK:  w = '{DP_NOP,         C_DATE_REFUSED, UA_EMIT};
				UA_COMMIT_DATE: w = '{DP_COMMIT_DATE, C_ALWAYS,       UA_WD_Q};
				UA_ADD_INIT:    w = '{DP_ADD_INIT,    C_ADD_REFUSED,  UA_EMIT};
				UA_WALK:        w = '{DP_ADD_WALK,    C_WALKING,      UA_WALK};
				UA_ADD_CHECK:   w = '{DP_NOP,         C_OVER,         UA_EMIT};
				UA_COMMIT_ADD:  w = '{DP_COMMIT_ADD,  C_NEVER,        UA_IDLE};
				UA_WD_Q:        w = '{DP_WD_Q,        C_NEVER,        UA_IDLE};
				UA_WD_R:        w = '{DP_WD_R,        C_NEVER,        UA_IDLE};
				UA_EMIT:        w = '{DP_EMIT,        C_OUT_BUSY,     UA_EMIT};
				default:        w = '{DP_NOP,         C_ALWAYS,       UA_IDLE};
			endcase
			return w;
		end
	endfunction

	function automatic logic [8:0] days_before(input logic [MW-1:0] m);
		logic [8:0] v;
		begin
			case (m)
				4'd0:    v = 9'd0;
				4'd1:    v = 9'd31;
				4'd2:    v = 9'd59;
				4'd3:    v = 9'd90;
				4'd4:    v = 9'd120;
				4'd5:    v = 9'd151;
				4'd6:    v = 9'd181;
				4'd7:    v = 9'd212;
				4'd8:    v = 9'd243;
				4'd9:    v = 9'd273;
				4'd10:   v = 9'd304;
				4'd11:   v = 9'd334;
				4'd12:   v = 9'd365;
				default: v = 9'd0;
			endcase
			return v;
		end
	endfunction

	// Zero for a month outside 1..12.
	function automatic logic [DW-1:0] month_len(input logic [MW-1:0] m, input logic leap);
		logic [DW-1:0] v;
		begin
			case (m)
				4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: v = 5'd31;
				4'd4, 4'd6, 4'd9, 4'd11:                    v = 5'd30;
				4'd2:    v = leap ? 5'd29 : 5'd28;
				default: v = 5'd0;
			endcase
			return v;
		end
	endfunction

endpackage

/* rtl/core/cdk_useq.sv */
// Microcode sequencer: step counter, control store and branch select.
module cdk_useq
	import cdk_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  seq_status_t status,
	output seq_ctrl_t   ctrl
);

	uaddr_t upc_q;
	uaddr_t upc_next;
	uword_t uw;
	logic   hit;

	assign uw = ucode(upc_q);

	always_comb begin
		unique case (uw.cond)
			C_NEVER:        hit = 1'b0;
			C_ALWAYS:       hit = 1'b1;
			C_NO_WORD:      hit = status.no_word;
			C_IS_ADD:       hit = status.is_add;
			C_BAD_OP:       hit = status.bad_op;
			C_DATE_REFUSED: hit = status.date_refused;
			C_ADD_REFUSED:  hit = status.add_refused;
			C_WALKING:      hit = status.walking;
			C_OVER:         hit = status.over;
			C_OUT_BUSY:     hit = status.out_busy;
			default:        hit = 1'b0;
		endcase
	end

	always_comb begin
		upc_next = hit ? uw.target : upc_q + uaddr_t'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= UA_IDLE;
		end else begin
			upc_q <= upc_next;
		end
	end

	always_comb begin
		ctrl.op   = uw.op;
		ctrl.idle = (upc_q == UA_IDLE);
	end

endmodule

/* rtl/core/calendar_date_keeper_core.sv */
// Calendar date keeper: microcoded datapath for date, day number and weekday.
// Load/set steps IDLE, DISPATCH, DIV100, MOD, BASE, SUM, DATE_CHECK, COMMIT_DATE,
// WD_Q, WD_R, EMIT; add steps ADD_INIT, WALK, ADD_CHECK, COMMIT_ADD, WD_Q, WD_R, EMIT;
// refused words go early to EMIT. Add walks one month per cycle in a single compare/subtract
// unit. One word in flight; next word accepted in the cycle after the result is registered.
// Reset: async active low; date 0001-01-01, day number 1, weekday 1, no result pending.
module calendar_date_keeper_core
	import cdk_pkg::*;
#(
	parameter int MAX_YEAR = CDK_MAX_YEAR
)
(
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  logic [OPW-1:0] opcode,
	input  logic [YW-1:0]  in_year,
	input  logic [MW-1:0]  in_month,
	input  logic [DW-1:0]  in_day,
	input  logic [NW-1:0]  add_count,
	output logic           out_valid,
	input  logic           out_stall,
	output logic           ok,
	output logic [YW-1:0]  cur_year,
	output logic [MW-1:0]  cur_month,
	output logic [DW-1:0]  cur_day,
	output logic [DNW-1:0] day_number,
	output logic [WKW-1:0] weekday
);

	localparam int DCW = $clog2(MAX_YEAR * 366 + 1);
	localparam int S7  = DCW + 3;
	localparam int PW7 = DCW + S7;
	localparam int unsigned M7 = ((1 << S7) + 6) / 7;
	localparam logic [YW-1:0] YEAR_TOP = YW'(MAX_YEAR);

	seq_ctrl_t   ctrl;
	seq_status_t status;

	// stored date
	logic [YW-1:0]    year_q;
	logic [MW-1:0]    month_q;
	logic [DW-1:0]    day_q;
	logic [DCW-1:0]   dc_q;
	logic [R100W-1:0] m100_q;
	logic [R400W-1:0] m400_q;
	logic [WKW-1:0]   wk_q;

	// latched word
	opcode_t        op_q;
	logic [YW-1:0]  iy_q;
	logic [MW-1:0]  im_q;
	logic [DW-1:0]  id_q;
	logic [NW-1:0]  n_q;

	// scratch
	logic [Q100W-1:0] q100_q;
	logic [R100W-1:0] r100_q;
	logic [R400W-1:0] r400_q;
	logic             legal_q;
	logic [DCW-1:0]   acc_q;
	logic [YW-1:0]    wy_q;
	logic [MW-1:0]    wm_q;
	logic [TDW-1:0]   td_q;
	logic [R100W-1:0] w100_q;
	logic [R400W-1:0] w400_q;
	logic             over_q;
	logic [DCW-1:0]   q7_q;
	logic             ok_q;

	// result word
	logic           out_valid_q;
	logic           ok_out_q;
	logic [YW-1:0]  year_out_q;
	logic [MW-1:0]  month_out_q;
	logic [DW-1:0]  day_out_q;
	logic [DNW-1:0] dn_out_q;
	logic [WKW-1:0] wk_out_q;

	logic             accept;
	logic             out_busy;
	logic [YW-1:0]    p;
	logic             in_leap;
	logic [DW-1:0]    in_len;
	logic             in_legal;
	logic [BASEW-1:0] base_prod;
	logic [P100W-1:0] prod100;
	logic [Q100W-1:0] q400;
	logic [Q100W-1:0] pd100;
	logic [Q100W-1:0] pd400;
	logic             w_leap;
	logic [DW-1:0]    w_len;
	logic [PW7-1:0]   prod7;

	cdk_useq u_useq (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.ctrl   (ctrl)
	);

	assign in_stall = !ctrl.idle;
	assign accept   = in_valid && !in_stall;
	assign out_busy = out_valid_q && out_stall;

	always_comb begin
		p         = iy_q - YW'(1);
		prod100   = P100W'(iy_q) * P100W'(RECIP100);
		q400      = q100_q >> 2;
		pd100     = (r100_q == '0) ? q100_q - Q100W'(1) : q100_q;
		pd400     = (r400_q == '0) ? q400 - Q100W'(1) : q400;
		in_leap   = ((iy_q[1:0] == 2'b00) && (r100_q != '0)) || (r400_q == '0);
		in_len    = month_len(im_q, in_leap);
		in_legal  = (iy_q != '0) && (iy_q <= YEAR_TOP) && (in_len != '0) &&
			(id_q != '0) && (id_q <= in_len);
		base_prod = BASEW'(p) * BASEW'(DAYS_YEAR);
		w_leap    = ((wy_q[1:0] == 2'b00) && (w100_q != '0)) || (w400_q == '0);
		w_len     = month_len(wm_q, w_leap);
		prod7     = PW7'(dc_q) * PW7'(M7);
	end

	always_comb begin
		status.no_word      = !in_valid;
		status.is_add       = (op_q == OP_ADD);
		status.bad_op       = (op_q == OP_NONE);
		status.date_refused = !legal_q || ((op_q == OP_SET) && (acc_q <= dc_q));
		status.add_refused  = (n_q == '0) || (32'(n_q) > 32'(CDK_MAX_ADD));
		status.walking      = (td_q > TDW'(w_len)) && !over_q;
		status.over         = over_q;
		status.out_busy     = out_busy;
	end

	// stored date and result control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			year_q      <= YW'(1);
			month_q     <= MW'(1);
			day_q       <= DW'(1);
			dc_q        <= DCW'(1);
			m100_q      <= R100W'(1);
			m400_q      <= R400W'(1);
			wk_q        <= WKW'(1);
			ok_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (ctrl.op)
				DP_LATCH: begin
					if (accept) begin
						ok_q <= 1'b0;
					end
				end
				DP_COMMIT_DATE: begin
					year_q  <= iy_q;
					month_q <= im_q;
					day_q   <= id_q;
					dc_q    <= acc_q;
					m100_q  <= r100_q;
					m400_q  <= r400_q;
					ok_q    <= 1'b1;
				end
				DP_COMMIT_ADD: begin
					year_q  <= wy_q;
					month_q <= wm_q;
					day_q   <= DW'(td_q);
					dc_q    <= dc_q + DCW'(n_q);
					m100_q  <= w100_q;
					m400_q  <= w400_q;
					ok_q    <= 1'b1;
				end
				DP_WD_R: begin
					wk_q <= WKW'(dc_q - q7_q * DCW'(7));
				end
				default: begin
				end
			endcase
			if (ctrl.op == DP_EMIT && !out_busy) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		unique case (ctrl.op)
			DP_LATCH: begin
				if (accept) begin
					op_q <= opcode_t'(opcode);
					iy_q <= in_year;
					im_q <= in_month;
					id_q <= in_day;
					n_q  <= add_count;
				end
			end
			DP_DIV100: begin
				q100_q <= Q100W'(prod100 >> DIV100_SHIFT);
			end
			DP_MOD: begin
				r100_q <= R100W'(iy_q - YW'(q100_q) * YW'(100));
				r400_q <= R400W'(iy_q - YW'(q400) * YW'(400));
			end
			DP_BASE: begin
				legal_q <= in_legal;
				acc_q   <= DCW'(base_prod) + DCW'(days_before(im_q - MW'(1))) + DCW'(id_q) +
					DCW'(in_leap && (im_q > MW'(2)));
			end
			DP_SUM: begin
				acc_q <= acc_q + DCW'(p >> 2) - DCW'(pd100) + DCW'(pd400);
			end
			DP_ADD_INIT: begin
				wy_q   <= year_q;
				wm_q   <= month_q;
				td_q   <= TDW'(day_q) + TDW'(n_q);
				w100_q <= m100_q;
				w400_q <= m400_q;
				over_q <= 1'b0;
			end
			DP_ADD_WALK: begin
				if (status.walking) begin
					td_q <= td_q - TDW'(w_len);
					if (wm_q == MW'(12)) begin
						wm_q <= MW'(1);
						if (wy_q == YEAR_TOP) begin
							over_q <= 1'b1;
						end else begin
							wy_q   <= wy_q + YW'(1);
							w100_q <= (w100_q == R100W'(99)) ? '0 : w100_q + R100W'(1);
							w400_q <= (w400_q == R400W'(399)) ? '0 : w400_q + R400W'(1);
						end
					end else begin
						wm_q <= wm_q + MW'(1);
					end
				end
			end
			DP_WD_Q: begin
				q7_q <= DCW'(prod7 >> S7);
			end
			DP_EMIT: begin
				if (!out_busy) begin
					ok_out_q    <= ok_q;
					year_out_q  <= year_q;
					month_out_q <= month_q;
					day_out_q   <= day_q;
					dn_out_q    <= DNW'(dc_q);
					wk_out_q    <= wk_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid  = out_valid_q;
	assign ok         = ok_out_q;
	assign cur_year   = year_out_q;
	assign cur_month  = month_out_q;
	assign cur_day    = day_out_q;
	assign day_number = dn_out_q;
	assign weekday    = wk_out_q;

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> in_stall)
		else $error("word accepted while previous word still in flight");

	a_weekday_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.idle |-> (DCW'(wk_q) == dc_q % DCW'(7)))
		else $error("weekday out of step with day number");

	a_date_sane: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.idle |-> ((month_q >= MW'(1)) && (month_q <= MW'(12)) &&
			(day_q != '0) && (dc_q != '0)))
		else $error("stored date not legal");

endmodule
